### sv/fcc_pkg.sv
// Shared constants, types and helpers of the frustum cull classifier.
package fcc_pkg;

  // Number of frustum planes held in configuration.
  localparam int PLANE_COUNT = 6;
  localparam int PLANE_IDX_W = 3;

  // Fixed point: normals are Q1.14, distances are compared at scale 2^14.
  localparam int FIX_SHIFT  = 14;
  localparam int COORD_W    = 16;
  localparam int EXT_W      = 15;
  localparam int PROD_W     = 32;
  localparam int NABS_W     = 17;
  localparam int MARGIN_W   = EXT_W + NABS_W;
  localparam int DIST_W     = 37;
  localparam int PLANE_W    = 64;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  // Classification codes carried in the result.
  typedef enum logic [1:0] {
    CLASS_OUTSIDE    = 2'd0,
    CLASS_INTERSECTS = 2'd1,
    CLASS_INSIDE     = 2'd2
  } class_t;

  // Shape kinds carried in the input user field.
  typedef enum logic {
    OP_SPHERE = 1'b0,
    OP_CUBE   = 1'b1
  } op_t;

  // One plane register: nx, ny, nz in Q1.14 and d in world units.
  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
  } plane_t;

  // Load enables of the pipeline stages shared by every plane lane.
  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } stage_en_t;

  // Magnitude of a Q1.14 component; the most negative code gives 2^15.
  function automatic logic [NABS_W-1:0] abs_norm(input logic signed [15:0] n);
    logic signed [NABS_W-1:0] wide;
    wide = NABS_W'(n);
    abs_norm = n[15] ? NABS_W'(-wide) : NABS_W'(wide);
  endfunction

endpackage

### sv/fcc_plane_lane.sv
// One plane lane: distance of the shape to one plane and its two verdict flags.
module fcc_plane_lane (
  input  logic                                clk,
  input  fcc_pkg::stage_en_t                  en,
  input  fcc_pkg::plane_t                     plane,
  input  logic signed [fcc_pkg::COORD_W-1:0]  center_x,
  input  logic signed [fcc_pkg::COORD_W-1:0]  center_y,
  input  logic signed [fcc_pkg::COORD_W-1:0]  center_z,
  input  logic                                op_a,
  input  logic [fcc_pkg::EXT_W-1:0]           ext_a,
  output logic                                outside,
  output logic                                full
);

  logic signed [fcc_pkg::PROD_W-1:0]   prod_x;
  logic signed [fcc_pkg::PROD_W-1:0]   prod_y;
  logic signed [fcc_pkg::PROD_W-1:0]   prod_z;
  logic [fcc_pkg::NABS_W-1:0]          nsum;
  logic [fcc_pkg::NABS_W-1:0]          nsum_next;
  logic signed [fcc_pkg::DIST_W-1:0]   distance_next;
  logic signed [fcc_pkg::DIST_W-1:0]   distance;
  logic [fcc_pkg::MARGIN_W-1:0]        margin_next;
  logic [fcc_pkg::MARGIN_W-1:0]        margin;
  logic signed [fcc_pkg::DIST_W-1:0]   d_scaled;
  logic signed [fcc_pkg::DIST_W-1:0]   lo;
  logic signed [fcc_pkg::DIST_W-1:0]   hi;

  // Sum of the normal magnitudes: how far a cube corner reaches per unit half size.
  assign nsum_next = fcc_pkg::abs_norm(plane.nx) + fcc_pkg::abs_norm(plane.ny)
                   + fcc_pkg::abs_norm(plane.nz);

  // Stage A: the three products of normal and centre.
  always_ff @(posedge clk) begin
    if (en.a) begin
      prod_x <= plane.nx * center_x;
      prod_y <= plane.ny * center_y;
      prod_z <= plane.nz * center_z;
      nsum   <= nsum_next;
    end
  end

  // Stage B: signed distance of the centre and the margin of the shape.
  // The sphere margin is the scaled radius; the cube margin is the largest
  // reach of a corner along the normal, half size times the magnitude sum.
  assign d_scaled      = {{(fcc_pkg::DIST_W - 16 - fcc_pkg::FIX_SHIFT){plane.d[15]}},
                          plane.d, {fcc_pkg::FIX_SHIFT{1'b0}}};
  assign distance_next = fcc_pkg::DIST_W'(prod_x) + fcc_pkg::DIST_W'(prod_y)
                       + fcc_pkg::DIST_W'(prod_z) + d_scaled;
  assign margin_next = (op_a == fcc_pkg::OP_CUBE)
                     ? ext_a * nsum
                     : {{(fcc_pkg::MARGIN_W - fcc_pkg::EXT_W - fcc_pkg::FIX_SHIFT){1'b0}},
                        ext_a, {fcc_pkg::FIX_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (en.b) begin
      distance <= distance_next;
      margin   <= margin_next;
    end
  end

  // Stage C: outside when even the far side of the shape is not above the
  // plane; fully in front when even the near side is above it.
  assign lo = distance + $signed({{(fcc_pkg::DIST_W - fcc_pkg::MARGIN_W){1'b0}}, margin});
  assign hi = distance - $signed({{(fcc_pkg::DIST_W - fcc_pkg::MARGIN_W){1'b0}}, margin});

  always_ff @(posedge clk) begin
    if (en.c) begin
      outside <= lo[fcc_pkg::DIST_W-1] || (lo == '0);
      full    <= !hi[fcc_pkg::DIST_W-1] && (hi != '0);
    end
  end

endmodule

### sv/frustum_cull_classifier_core.sv
// Top level of the frustum cull classifier: plane registers, stage control, verdict.
//
// Classifies a sphere (tuser 0) or an axis-aligned cube (tuser 1) against six
// frustum planes written through the configuration port, and returns one class
// per shape: 0 outside, 1 intersecting, 2 fully inside. The block takes one
// shape per clock cycle while the output side does not stall. A shape's result
// passes through one stage for the normal-by-centre multipliers, one for the
// distance sum and the cube margin multiplier, one for the plane compares and
// one for combining the six plane verdicts in the output register. Each stage moves when the stage
// after it is empty or moving, so bubbles close up and input tready follows
// output tready through that chain. Planes must be written only while no shape
// is in flight.
module frustum_cull_classifier_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [fcc_pkg::PLANE_IDX_W-1:0]      cfg_addr,
  input  logic [fcc_pkg::PLANE_W-1:0]          cfg_wdata,
  // Shape input.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata: center_x[15:0], center_y[31:16], center_z[47:32], extent[62:48], zero[63].
  input  logic [fcc_pkg::IN_DATA_W-1:0]        s_tdata,
  // s_tuser: op[0].
  input  logic                                 s_tuser,
  // Class output.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata: result_class[1:0], zero[7:2].
  output logic [fcc_pkg::OUT_DATA_W-1:0]       m_tdata
);

  fcc_pkg::plane_t               planes [fcc_pkg::PLANE_COUNT];
  fcc_pkg::stage_en_t            en;
  logic                          en_d;
  logic                          v_a;
  logic                          v_b;
  logic                          v_c;
  logic                          op_a;
  logic [fcc_pkg::EXT_W-1:0]     ext_a;
  logic [fcc_pkg::PLANE_COUNT-1:0] outside_c;
  logic [fcc_pkg::PLANE_COUNT-1:0] full_c;
  fcc_pkg::class_t               class_next;
  fcc_pkg::class_t               result_class;

  // Plane registers; writes beyond the last plane are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < fcc_pkg::PLANE_COUNT; p++) begin
        planes[p] <= '0;
      end
    end else if (cfg_we && (cfg_addr < fcc_pkg::PLANE_IDX_W'(fcc_pkg::PLANE_COUNT))) begin
      planes[cfg_addr] <= fcc_pkg::plane_t'(cfg_wdata);
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  assign en_d     = !m_tvalid || m_tready;
  assign en.c     = !v_c || en_d;
  assign en.b     = !v_b || en.c;
  assign en.a     = !v_a || en.b;
  assign s_tready = en.a;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a      <= 1'b0;
      v_b      <= 1'b0;
      v_c      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en.a) v_a      <= s_tvalid;
      if (en.b) v_b      <= v_a;
      if (en.c) v_c      <= v_b;
      if (en_d) m_tvalid <= v_c;
    end
  end

  // Shape kind and extent held for the margin stage.
  always_ff @(posedge clk) begin
    if (en.a) begin
      op_a  <= s_tuser;
      ext_a <= s_tdata[62:48];
    end
  end

  // One lane per plane, all working on the same shape.
  for (genvar p = 0; p < fcc_pkg::PLANE_COUNT; p++) begin : g_lane
    fcc_plane_lane u_lane (
      .clk      (clk),
      .en       (en),
      .plane    (planes[p]),
      .center_x (s_tdata[15:0]),
      .center_y (s_tdata[31:16]),
      .center_z (s_tdata[47:32]),
      .op_a     (op_a),
      .ext_a    (ext_a),
      .outside  (outside_c[p]),
      .full     (full_c[p])
    );
  end

  // Combine the plane verdicts: any plane outside wins, then all planes full.
  always_comb begin
    if (|outside_c) begin
      class_next = fcc_pkg::CLASS_OUTSIDE;
    end else if (&full_c) begin
      class_next = fcc_pkg::CLASS_INSIDE;
    end else begin
      class_next = fcc_pkg::CLASS_INTERSECTS;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en_d) begin
      result_class <= class_next;
    end
  end

  assign m_tdata = {{(fcc_pkg::OUT_DATA_W - 2){1'b0}}, result_class};

  // An accepted shape always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v_a)
    else $error("accepted shape did not enter the first stage");

  // With every stage full and the output stalled, no shape may be taken.
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (v_a && v_b && v_c && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while the pipeline is full and stalled");

  // A plane can never judge a shape both outside and fully in front.
  a_flags_consistent: assert property (@(posedge clk) disable iff (rst)
    v_c |-> ((outside_c & full_c) == '0))
    else $error("plane verdicts outside and full at once");

  // A result in the compare stage moves to the output when it is free.
  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (v_c && en_d) |=> m_tvalid)
    else $error("compared shape lost before the output register");

endmodule

### test/testbench.sv
// Self-checking testbench of the frustum cull classifier: stream stimulus, scoreboard, checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Q1.14 unit and 1/sqrt(2) used to build the plane sets.
  localparam int ONE          = 16384;
  localparam int DIAG         = 11585;
  localparam int CORNER_COUNT = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 155;
  localparam int PHASE_COUNT  = 6;

  // Register indexes of the configuration port; the last two are not decoded.
  typedef enum logic [fcc_pkg::PLANE_IDX_W-1:0] {
    REG_LEFT, REG_RIGHT, REG_TOP, REG_BOTTOM, REG_NEAR, REG_FAR, REG_SPARE_A, REG_SPARE_B
  } plane_reg_t;

  typedef enum int {
    CFG_BOX, CFG_PERSPECTIVE, CFG_EXTREME, CFG_RANDOM, CFG_RANDOM_BOX, CFG_WIDE_BOX
  } plane_setup_t;

  typedef enum int {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_mode_t;

  // Holds the plane set the block should be using and the classes still owed by it.
  class cull_scoreboard;
    fcc_pkg::plane_t planes [fcc_pkg::PLANE_COUNT];
    fcc_pkg::class_t class_q [$];
    int unsigned errors;

    function new();
      foreach (planes[i]) planes[i] = '0;
      errors = 0;
    endfunction

    function void set_plane(int unsigned idx, logic [fcc_pkg::PLANE_W-1:0] value);
      if (idx < fcc_pkg::PLANE_COUNT) planes[idx] = fcc_pkg::plane_t'(value);
    endfunction

    function int unsigned pending();
      return class_q.size();
    endfunction

    // Signed distance of a point at scale 2^14, exact in 64 bits.
    function longint plane_dist(fcc_pkg::plane_t pl, longint px, longint py, longint pz);
      longint nx, ny, nz, d;
      nx = longint'(pl.nx);
      ny = longint'(pl.ny);
      nz = longint'(pl.nz);
      d  = longint'(pl.d);
      return nx * px + ny * py + nz * pz + d * ONE;
    endfunction

    function fcc_pkg::class_t classify(fcc_pkg::op_t op, longint cx, longint cy, longint cz,
                                       longint ext);
      longint lim, distance, px, py, pz;
      int above, clear;
      lim   = ext * ONE;
      clear = 0;
      for (int p = 0; p < fcc_pkg::PLANE_COUNT; p++) begin
        if (op == fcc_pkg::OP_SPHERE) begin
          distance = plane_dist(planes[p], cx, cy, cz);
          if (distance <= -lim) return fcc_pkg::CLASS_OUTSIDE;
          if (distance > lim) clear++;
        end else begin
          // Count the cube corners strictly on the inner side of this plane.
          above = 0;
          for (int k = 0; k < CORNER_COUNT; k++) begin
            px = k[0] ? cx + ext : cx - ext;
            py = k[1] ? cy + ext : cy - ext;
            pz = k[2] ? cz + ext : cz - ext;
            if (plane_dist(planes[p], px, py, pz) > 0) above++;
          end
          if (above == 0) return fcc_pkg::CLASS_OUTSIDE;
          if (above == CORNER_COUNT) clear++;
        end
      end
      return (clear == fcc_pkg::PLANE_COUNT) ? fcc_pkg::CLASS_INSIDE
                                             : fcc_pkg::CLASS_INTERSECTS;
    endfunction

    function void note_shape(fcc_pkg::op_t op, logic signed [15:0] cx,
                             logic signed [15:0] cy, logic signed [15:0] cz,
                             logic [fcc_pkg::EXT_W-1:0] ext);
      class_q.push_back(classify(op, longint'(cx), longint'(cy), longint'(cz),
                                 longint'(ext)));
    endfunction

    function void check_result(logic [fcc_pkg::OUT_DATA_W-1:0] data);
      fcc_pkg::class_t want;
      if (class_q.size() == 0) begin
        $error("result transfer with no class pending: data %0h", data);
        errors++;
        return;
      end
      want = class_q.pop_front();
      if (data[1:0] != want) begin
        $error("result_class: expected %0d, got %0d", want, data[1:0]);
        errors++;
      end
      if (data[fcc_pkg::OUT_DATA_W-1:2] != '0) begin
        $error("tdata padding: expected 0, got %0h", data[fcc_pkg::OUT_DATA_W-1:2]);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [fcc_pkg::PLANE_IDX_W-1:0] cfg_addr;
  logic [fcc_pkg::PLANE_W-1:0]     cfg_wdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [fcc_pkg::IN_DATA_W-1:0]   s_tdata;
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [fcc_pkg::OUT_DATA_W-1:0]  m_tdata;

  cull_scoreboard sb;
  logic [fcc_pkg::PLANE_W-1:0] cfg_planes [fcc_pkg::PLANE_COUNT];
  int shape_scale;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  frustum_cull_classifier_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: check each transfer, then pick the next tready.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [fcc_pkg::PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
    return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic logic signed [15:0] clamp_coord(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        send_idle_pct = 16;
        recv_idle_pct = 56;
      end
      IDLE_SENDER_HEAVY: begin
        send_idle_pct = 56;
        recv_idle_pct = 16;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Axis-aligned box; each plane keeps points with coordinate within its distance.
  task automatic set_box(int l, int r, int t, int b, int n, int f);
    cfg_planes[REG_LEFT]   = pack_plane(ONE, 0, 0, l);
    cfg_planes[REG_RIGHT]  = pack_plane(-ONE, 0, 0, r);
    cfg_planes[REG_TOP]    = pack_plane(0, -ONE, 0, t);
    cfg_planes[REG_BOTTOM] = pack_plane(0, ONE, 0, b);
    cfg_planes[REG_NEAR]   = pack_plane(0, 0, ONE, n);
    cfg_planes[REG_FAR]    = pack_plane(0, 0, -ONE, f);
  endtask

  task automatic setup_planes(plane_setup_t kind);
    case (kind)
      CFG_BOX: begin
        set_box(1000, 1000, 1000, 1000, 1000, 1000);
        shape_scale = 1000;
      end
      CFG_WIDE_BOX: begin
        set_box(20000, 20000, 20000, 20000, 20000, 20000);
        shape_scale = 24000;
      end
      CFG_RANDOM_BOX: begin
        set_box($urandom_range(0, 32767), $urandom_range(0, 32767),
                $urandom_range(0, 32767), $urandom_range(0, 32767),
                $urandom_range(0, 32767), $urandom_range(0, 32767));
        shape_scale = 16000;
      end
      CFG_PERSPECTIVE: begin
        // Ninety degree view along +z between z = 10 and z = 20000.
        cfg_planes[REG_LEFT]   = pack_plane(DIAG, 0, DIAG, 0);
        cfg_planes[REG_RIGHT]  = pack_plane(-DIAG, 0, DIAG, 0);
        cfg_planes[REG_TOP]    = pack_plane(0, -DIAG, DIAG, 0);
        cfg_planes[REG_BOTTOM] = pack_plane(0, DIAG, DIAG, 0);
        cfg_planes[REG_NEAR]   = pack_plane(0, 0, ONE, -10);
        cfg_planes[REG_FAR]    = pack_plane(0, 0, -ONE, 20000);
        shape_scale = 2000;
      end
      CFG_EXTREME: begin
        cfg_planes[REG_LEFT]   = 64'h7FFF_8000_7FFF_8000;
        cfg_planes[REG_RIGHT]  = 64'h8000_7FFF_8000_7FFF;
        cfg_planes[REG_TOP]    = 64'h8000_8000_8000_8000;
        cfg_planes[REG_BOTTOM] = 64'h7FFF_7FFF_7FFF_7FFF;
        cfg_planes[REG_NEAR]   = 64'hFFFF_FFFF_FFFF_FFFF;
        cfg_planes[REG_FAR]    = 64'h0;
        shape_scale = 32767;
      end
      default: begin
        foreach (cfg_planes[i]) cfg_planes[i] = {$urandom, $urandom};
        shape_scale = 32767;
      end
    endcase
  endtask

  // Write all six planes, then junk to the undecoded indexes.
  task automatic write_config();
    for (int i = 0; i < fcc_pkg::PLANE_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= plane_reg_t'(i);
      cfg_wdata <= cfg_planes[i];
      @(posedge clk);
      sb.set_plane(i, cfg_planes[i]);
    end
    cfg_addr  <= REG_SPARE_A;
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_addr  <= REG_SPARE_B;
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one shape and hold it until the transfer happens.
  task automatic send_shape(fcc_pkg::op_t op, logic signed [15:0] cx,
                            logic signed [15:0] cy, logic signed [15:0] cz,
                            logic [fcc_pkg::EXT_W-1:0] ext);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, ext, cz, cy, cx};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_shape(op, cx, cy, cz, ext);
  endtask

  // Mostly shapes around the frustum, some anywhere, some on the field limits.
  task automatic send_random_shape();
    logic signed [15:0] c [3];
    logic [fcc_pkg::EXT_W-1:0] ext;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      foreach (c[i]) c[i] = clamp_coord(int'($urandom_range(0, 4 * shape_scale)) -
                                        2 * shape_scale);
      ext = fcc_pkg::EXT_W'($urandom_range(0, shape_scale / 2));
    end else if (pick < 90) begin
      foreach (c[i]) c[i] = 16'($urandom);
      ext = fcc_pkg::EXT_W'($urandom);
    end else begin
      foreach (c[i]) begin
        case ($urandom_range(0, 4))
          0: c[i] = 16'sh8000;
          1: c[i] = 16'sh7FFF;
          2: c[i] = -16'sd1;
          3: c[i] = 16'sd1;
          default: c[i] = 16'sd0;
        endcase
      end
      case ($urandom_range(0, 2))
        0: ext = '0;
        1: ext = fcc_pkg::EXT_W'(1);
        default: ext = '1;
      endcase
    end
    send_shape(fcc_pkg::op_t'($urandom_range(0, 1)), c[0], c[1], c[2], ext);
  endtask

  // Stop offering, then wait for every owed class and the pipeline to empty.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Main sequence: reset, directed shapes, then random phases over several plane sets.
  initial begin
    plane_setup_t setups [PHASE_COUNT];
    idle_mode_t modes [PHASE_COUNT];
    setups = '{CFG_BOX, CFG_PERSPECTIVE, CFG_EXTREME, CFG_RANDOM, CFG_RANDOM_BOX,
               CFG_WIDE_BOX};
    modes  = '{IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE, IDLE_SENDER_LIGHT,
               IDLE_SENDER_HEAVY, IDLE_NONE};
    sb = new();
    hold_req  = 1'b0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    set_idle(IDLE_NONE);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All planes zero after reset: only a sphere with nonzero radius is not outside.
    send_shape(fcc_pkg::OP_SPHERE, 0, 0, 0, 0);
    send_shape(fcc_pkg::OP_SPHERE, 123, -45, 6, 5);
    send_shape(fcc_pkg::OP_CUBE, 0, 0, 0, 7);
    send_shape(fcc_pkg::OP_CUBE, -32768, 32767, -1, 32767);
    wait_idle();

    // Box of half width 1000: clear cases, touching and boundary cases, field limits.
    setup_planes(CFG_BOX);
    write_config();
    set_idle(IDLE_SENDER_LIGHT);
    send_shape(fcc_pkg::OP_SPHERE, 0, 0, 0, 10);
    send_shape(fcc_pkg::OP_SPHERE, 5000, 0, 0, 10);
    send_shape(fcc_pkg::OP_SPHERE, -990, 0, 0, 10);
    send_shape(fcc_pkg::OP_SPHERE, -1010, 0, 0, 10);
    send_shape(fcc_pkg::OP_SPHERE, 0, 0, 0, 0);
    send_shape(fcc_pkg::OP_CUBE, 0, 0, 0, 100);
    send_shape(fcc_pkg::OP_CUBE, 0, 0, 0, 1000);
    send_shape(fcc_pkg::OP_CUBE, 2000, 0, 0, 1000);
    send_shape(fcc_pkg::OP_CUBE, 0, 0, 999, 1);
    send_shape(fcc_pkg::OP_SPHERE, -32768, -32768, -32768, 32767);
    send_shape(fcc_pkg::OP_CUBE, -32768, -32768, -32768, 32767);
    send_shape(fcc_pkg::OP_SPHERE, 32767, 32767, 32767, 32767);
    send_shape(fcc_pkg::OP_CUBE, 32767, 32767, 32767, 32767);
    send_shape(fcc_pkg::OP_CUBE, 32767, -32768, 0, 0);
    send_shape(fcc_pkg::OP_SPHERE, -1, -1, -1, 15'h7FFF);
    wait_idle();

    // Random phases; the first one also stalls the result side for a long stretch.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      setup_planes(setups[ph]);
      write_config();
      set_idle(modes[ph]);
      if (ph == 0) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_shape();
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
